@@ hdl/battery_level_estimator_assert.svh @@
// Assertion macros shared by the battery level estimator RTL.
`ifndef BATTERY_LEVEL_ESTIMATOR_ASSERT_SVH
`define BATTERY_LEVEL_ESTIMATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising edge outside reset.
`define BLE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define BLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define BLE_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define BLE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ hdl/ble_pkg.sv @@
// Types, widths and discharge-curve constants for the battery level estimator.
`default_nettype none
package ble_pkg;

   localparam int ADC_BITS   = 12;
   localparam int MV_W       = 14;
   localparam int THR_W      = 13;
   localparam int PCT_W      = 7;
   localparam int PROD_W     = ADC_BITS + MV_W;
   localparam int LUT_POINTS = 13;
   localparam int SEGS       = LUT_POINTS - 1;
   localparam int SEG_W      = 4;
   localparam int DELTA_W    = 7;
   localparam int STEP_W     = 4;
   localparam int NUM_W      = 10;
   localparam int STEP_MAX   = 10;

   typedef logic [SEG_W-1:0] seg_type;

   typedef enum logic [0:0] {
      CSR_FULL_SCALE    = 1'b0,
      CSR_LOW_THRESHOLD = 1'b1
   } csr_index_type;

   // Discharge curve, highest voltage first.
   localparam logic [MV_W-1:0] LUT_MV [LUT_POINTS] = '{
      14'd4150, 14'd4050, 14'd3970, 14'd3900, 14'd3800, 14'd3730, 14'd3670,
      14'd3610, 14'd3560, 14'd3500, 14'd3420, 14'd3350, 14'd3250
   };

   localparam logic [PCT_W-1:0] LUT_PCT [LUT_POINTS] = '{
      7'd100, 7'd95, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50,
      7'd40, 7'd30, 7'd20, 7'd10, 7'd5, 7'd0
   };

   localparam logic [MV_W-1:0] FULL_SCALE_RESET    = 14'd6600;
   localparam logic [THR_W-1:0] LOW_THRESHOLD_RESET = 13'd3400;

   // Voltage span of segment s (between point s and point s+1).
   function automatic logic [DELTA_W-1:0] seg_span(input seg_type s);
      logic [MV_W-1:0] d;
      d = LUT_MV[s] - LUT_MV[SEG_W'(s + 1'b1)];
      return d[DELTA_W-1:0];
   endfunction

   // Percent step across segment s.
   function automatic logic [STEP_W-1:0] seg_step(input seg_type s);
      logic [PCT_W-1:0] d;
      d = LUT_PCT[s] - LUT_PCT[SEG_W'(s + 1'b1)];
      return d[STEP_W-1:0];
   endfunction

endpackage
`default_nettype wire

@@ hdl/battery_level_estimator.sv @@
// Top level of the battery level estimator: four-stage conversion and interpolation pipeline.
`default_nettype none

// The block turns each ADC sample into battery millivolts as
// floor(adc_code * full_scale_mv / 4096), flags the sample as low when that
// voltage is strictly below low_threshold_mv, and estimates the state of
// charge by linear interpolation on a fixed 13-point lithium-polymer
// discharge curve, clamped to 100 at 4150 mV and above and to 0 at 3250 mV
// and below. It accepts one transfer per clock cycle while the result side
// does not stall, and passes each result through four register stages:
// the scaling multiply, the curve segment search, the small interpolation
// multiply, and the division by the segment span, done as a parallel compare
// against its multiples. A stall on the result side freezes the whole
// pipeline in place and is passed back to the input as req_stall in the
// same cycle, so nothing is dropped or repeated. The configuration registers
// are written through the csr_ port and must only change while no sample is
// in flight; they are not read back.
module battery_level_estimator
   import ble_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,

   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [ADC_BITS-1:0] req_adc_code,

   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [MV_W-1:0]          rsp_battery_mv,
   output logic [PCT_W-1:0]         rsp_charge_percent,
   output logic                     rsp_low_battery,

   input  wire logic                csr_we,
   input  wire csr_index_type       csr_index,
   input  wire logic [MV_W-1:0]     csr_wdata
);

`include "battery_level_estimator_assert.svh"

   // Configuration registers.
   logic [MV_W-1:0]  full_scale_ff;
   logic [THR_W-1:0] low_threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff    <= FULL_SCALE_RESET;
         low_threshold_ff <= LOW_THRESHOLD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FULL_SCALE:    full_scale_ff    <= csr_wdata;
            CSR_LOW_THRESHOLD: low_threshold_ff <= csr_wdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   // The pipeline moves as one; it holds only while a result waits.
   logic advance;
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // Stage 1: scale the sample.
   logic              s1_valid_ff, s1_valid_in;
   logic [PROD_W-1:0] s1_prod_ff, s1_prod_in;

   assign s1_valid_in = req_valid;
   assign s1_prod_in  = PROD_W'(req_adc_code) * PROD_W'(full_scale_ff);

   // Stage 2: locate the curve segment and the offset into it.
   logic               s2_valid_ff, s2_valid_in;
   logic [MV_W-1:0]    s2_mv_ff, s2_mv_in;
   logic               s2_low_ff, s2_low_in;
   seg_type            s2_seg_ff, s2_seg_in;
   logic [DELTA_W-1:0] s2_delta_ff, s2_delta_in;
   logic [MV_W-1:0]    s2_diff;

   assign s2_valid_in = s1_valid_ff;
   assign s2_mv_in    = s1_prod_ff[ADC_BITS +: MV_W];
   assign s2_low_in   = s2_mv_in < MV_W'(low_threshold_ff);

   always_comb begin
      s2_seg_in = SEG_W'(SEGS - 1);
      for (int k = 0; k < SEGS; k++) begin
         if (s2_mv_in <= LUT_MV[k] && s2_mv_in > LUT_MV[k+1]) begin
            s2_seg_in = SEG_W'(k);
         end
      end
      s2_diff = s2_mv_in - LUT_MV[SEG_W'(s2_seg_in + 1'b1)];
      // At or above the top point, the full first segment gives exactly 100.
      if (s2_mv_in >= LUT_MV[0]) begin
         s2_seg_in   = '0;
         s2_delta_in = seg_span('0);
      end else if (s2_mv_in <= LUT_MV[LUT_POINTS-1]) begin
         s2_delta_in = '0;
      end else begin
         s2_delta_in = s2_diff[DELTA_W-1:0];
      end
   end

   // Stage 3: offset times percent step.
   logic             s3_valid_ff, s3_valid_in;
   logic [MV_W-1:0]  s3_mv_ff;
   logic             s3_low_ff;
   seg_type          s3_seg_ff;
   logic [NUM_W-1:0] s3_num_ff, s3_num_in;

   assign s3_valid_in = s2_valid_ff;
   assign s3_num_in   = NUM_W'(s2_delta_ff) * NUM_W'(seg_step(s2_seg_ff));

   // Stage 4: divide by the segment span and add the segment base.
   logic              s4_valid_in;
   logic [STEP_W-1:0] s4_quot;
   logic [PCT_W-1:0]  s4_pct_in;
   logic [NUM_W-1:0]  s4_span;

   always_comb begin
      s4_quot = '0;
      s4_span = NUM_W'(seg_span(s3_seg_ff));
      // The quotient never exceeds the percent step, so a count of the
      // multiples of the span that fit is an exact floor division.
      for (int j = 1; j <= STEP_MAX; j++) begin
         if (s3_num_ff >= NUM_W'(j) * s4_span) begin
            s4_quot = s4_quot + 1'b1;
         end
      end
      s4_pct_in = LUT_PCT[SEG_W'(s3_seg_ff + 1'b1)] + PCT_W'(s4_quot);
   end

   assign s4_valid_in = s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         rsp_valid   <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         rsp_valid   <= s4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_prod_ff         <= s1_prod_in;
         s2_mv_ff           <= s2_mv_in;
         s2_low_ff          <= s2_low_in;
         s2_seg_ff          <= s2_seg_in;
         s2_delta_ff        <= s2_delta_in;
         s3_mv_ff           <= s2_mv_ff;
         s3_low_ff          <= s2_low_ff;
         s3_seg_ff          <= s2_seg_ff;
         s3_num_ff          <= s3_num_in;
         rsp_battery_mv     <= s3_mv_ff;
         rsp_low_battery    <= s3_low_ff;
         rsp_charge_percent <= s4_pct_in;
      end
   end

   // Checks on the interpolation and the pipeline hold.
   `BLE_ASSERT_IMPLY(a_pct_range, clock, reset, rsp_valid, rsp_charge_percent <= PCT_W'(100))
   `BLE_ASSERT_IMPLY(a_top_clamp, clock, reset, rsp_valid && rsp_battery_mv >= LUT_MV[0], rsp_charge_percent == PCT_W'(100))
   `BLE_ASSERT_IMPLY(a_bottom_clamp, clock, reset, rsp_valid && rsp_battery_mv <= LUT_MV[LUT_POINTS-1], rsp_charge_percent == '0)
   `BLE_ASSERT_NEXT(a_hold, clock, reset, !advance, $stable({s1_valid_ff, s2_valid_ff, s3_valid_ff}))

endmodule
`default_nettype wire
